>>> src/kfd_pkg.sv
// Shared types, widths and helpers for the HEVC keyframe detector.
// No dependencies; every other file but kfd_flag_if uses this package.
package kfd_pkg;

  localparam int unsigned LenBits    = 24;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned PrefixBits = 32;

  localparam logic [ByteBits-1:0] ZeroByte = 8'h00;
  localparam logic [ByteBits-1:0] OneByte  = 8'h01;
  localparam logic [5:0]          TypeMask = 6'h3F;
  localparam logic [5:0]          IrapLow  = 6'd16;
  localparam logic [5:0]          IrapHigh = 6'd21;
  localparam logic [LenBits-1:0]  MinLen   = LenBits'(6);

  typedef struct packed {
    logic [ByteBits-1:0] byte_value;
    logic [LenBits-1:0]  buffer_length;
    logic                last_byte;
  } byte_item_t;

  // NAL unit type 16..21 (BLA, IDR, CRA) marks a random access point.
  function automatic logic is_irap(input logic [ByteBits-1:0] hdr);
    logic [5:0] nal_type;
    nal_type = hdr[6:1] & TypeMask;
    return (nal_type >= IrapLow) && (nal_type <= IrapHigh);
  endfunction

endpackage

>>> src/kfd_byte_if.sv
// Byte channel into the keyframe detector: valid/ready plus one buffer byte.
// Depends on kfd_pkg for the field widths.
interface kfd_byte_if;
  logic                          valid;
  logic                          ready;
  logic [kfd_pkg::ByteBits-1:0]  byte_value;
  logic [kfd_pkg::LenBits-1:0]   buffer_length;
  logic                          last_byte;

  modport source (output valid, byte_value, buffer_length, last_byte, input ready);
  modport sink   (input valid, byte_value, buffer_length, last_byte, output ready);
endinterface

>>> src/kfd_flag_if.sv
// Result channel out of the keyframe detector: valid/ready plus the flag.
// No dependencies.
interface kfd_flag_if;
  logic valid;
  logic ready;
  logic keyframe_found;

  modport source (output valid, keyframe_found, input ready);
  modport sink   (input valid, keyframe_found, output ready);
endinterface

>>> src/hevc_keyframe_detector_top.sv
// Top level of the HEVC keyframe detector: input register, scanner, result register.
// Depends on kfd_pkg, kfd_byte_if, kfd_flag_if and kfd_scan.
//
//   channel  dir  payload                                  transaction
//   bytes    in   byte_value[7:0] buffer_length[23:0]      one buffer byte
//                 last_byte
//   result   out  keyframe_found                           one flag per buffer
//
// Flow: one byte per clock unless a last byte is held; a byte waits in the input
//   register and its scan update completes as it leaves, where a last byte also
//   loads the result register, from which the flag is offered.
// Reset: rst (synchronous) clears both valid flags and all scan state.
// Stalls: only a last byte is held, and only while the previous flag is unread;
//   other bytes flow regardless of result.ready, unless queued behind a held one.
module hevc_keyframe_detector_top (
  input logic        clk,
  input logic        rst,
  kfd_byte_if.sink   bytes,
  kfd_flag_if.source result
);
  import kfd_pkg::*;

  logic       in_valid;    // input register holds a byte
  byte_item_t in_item;
  logic       fire;        // scan consumes the registered byte this cycle
  logic       found;
  logic       out_valid;
  logic       out_flag;

  // A non-last byte never needs the result slot; a last byte needs it free.
  assign fire        = in_valid && (!in_item.last_byte || !out_valid || result.ready);
  assign bytes.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_item.byte_value    <= bytes.byte_value;
      in_item.buffer_length <= bytes.buffer_length;
      in_item.last_byte     <= bytes.last_byte;
    end
  end

  kfd_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (in_item),
    .found (found)
  );

  // Result register: loads on the last byte of a buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.last_byte) begin
      out_flag <= found;
    end
  end

  assign result.valid          = out_valid;
  assign result.keyframe_found = out_flag;

endmodule

>>> src/kfd_scan.sv
// Per-buffer scan state and the combinational update of both scanners.
// Depends on kfd_pkg.
module kfd_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  kfd_pkg::byte_item_t item,
  output logic                found
);
  import kfd_pkg::*;

  logic [LenBits-1:0]    byte_position, byte_position_next;
  logic [4*ByteBits-1:0] byte_window;
  logic [LenBits-1:0]    next_scan_position, next_scan_position_next;
  logic [LenBits-1:0]    next_prefix_position, next_prefix_position_next;
  logic                  prefix_walk_stopped, prefix_walk_stopped_next;
  logic                  irap_seen, irap_seen_next;

  logic [ByteBits-1:0]   b, w1, w2, w3, w4, hdr;
  logic [LenBits:0]      p_ext, size_ext;
  logic                  size_ok, active, ab_check, sc3, sc4, ab_hit;
  logic                  pf_check, pf_stop;
  logic [PrefixBits:0]   pf_end;

  assign b  = item.byte_value;
  assign w1 = byte_window[ByteBits-1:0];
  assign w2 = byte_window[2*ByteBits-1:ByteBits];
  assign w3 = byte_window[3*ByteBits-1:2*ByteBits];
  assign w4 = byte_window[4*ByteBits-1:3*ByteBits];

  always_comb begin
    p_ext    = {1'b0, byte_position};
    size_ext = {1'b0, item.buffer_length};
    size_ok  = item.buffer_length >= MinLen;
    active   = size_ok && (byte_position >= LenBits'(4));

    // Annex-B: candidate at p-4, window and current byte hold the five bytes from there.
    ab_check = active && (p_ext >= ({1'b0, next_scan_position} + (LenBits+1)'(4)))
               && ((p_ext + (LenBits+1)'(1)) < size_ext);
    sc3      = (w4 == ZeroByte) && (w3 == ZeroByte) && (w2 == OneByte);
    sc4      = (w4 == ZeroByte) && (w3 == ZeroByte) && (w2 == ZeroByte) && (w1 == OneByte);
    ab_hit   = ab_check && (sc3 || sc4);
    hdr      = sc3 ? w1 : b;

    // Length prefix sits in the window, unit header is the current byte.
    pf_check = active && !prefix_walk_stopped
               && (p_ext == ({1'b0, next_prefix_position} + (LenBits+1)'(4)))
               && (p_ext < size_ext);
    pf_end   = (PrefixBits+1)'(byte_position) + {1'b0, byte_window};
    pf_stop  = (byte_window == '0) || (pf_end > (PrefixBits+1)'(item.buffer_length));

    next_scan_position_next   = next_scan_position;
    next_prefix_position_next = next_prefix_position;
    prefix_walk_stopped_next  = prefix_walk_stopped;
    irap_seen_next            = irap_seen;

    if (ab_hit) begin
      next_scan_position_next = sc3 ? byte_position : byte_position + LenBits'(1);
      if (is_irap(hdr)) begin
        irap_seen_next = 1'b1;
      end
    end

    if (pf_check) begin
      if (pf_stop) begin
        prefix_walk_stopped_next = 1'b1;
      end else begin
        next_prefix_position_next = byte_position + byte_window[LenBits-1:0];
        if (is_irap(b)) begin
          irap_seen_next = 1'b1;
        end
      end
    end

    byte_position_next = (byte_position == '1) ? byte_position
                                               : byte_position + LenBits'(1);
    found = irap_seen_next && size_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      byte_window          <= '0;
      next_scan_position   <= '0;
      next_prefix_position <= '0;
      prefix_walk_stopped  <= 1'b0;
      irap_seen            <= 1'b0;
    end else if (fire) begin
      if (item.last_byte) begin
        byte_position        <= '0;
        byte_window          <= '0;
        next_scan_position   <= '0;
        next_prefix_position <= '0;
        prefix_walk_stopped  <= 1'b0;
        irap_seen            <= 1'b0;
      end else begin
        byte_position        <= byte_position_next;
        byte_window          <= {byte_window[3*ByteBits-1:0], b};
        next_scan_position   <= next_scan_position_next;
        next_prefix_position <= next_prefix_position_next;
        prefix_walk_stopped  <= prefix_walk_stopped_next;
        irap_seen            <= irap_seen_next;
      end
    end
  end

endmodule

>>> tb/sv/hevc_keyframe_detector_top_tb.sv
// Self-checking testbench for hevc_keyframe_detector_top: random and directed HEVC buffers,
// one IRAP flag predicted per buffer and compared with each result transaction.
// Depends on kfd_pkg, kfd_byte_if, kfd_flag_if and the detector RTL.
module hevc_keyframe_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kfd_pkg::*;

  localparam int HoldCycles    = 400;   // long receiver hold-off in the backpressure phase
  localparam int WatchdogLimit = 5000;  // cycles with no transaction before giving up
  localparam int MaxReports    = 10;

  typedef enum logic [2:0] {
    PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE
  } phase_t;

  logic clk;
  logic rst;

  kfd_byte_if byte_ch ();
  kfd_flag_if flag_ch ();

  hevc_keyframe_detector_top dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .result (flag_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shared state: byte transactions waiting to be sent, flags still owed by the
  // block, and the knobs of the current phase.
  // ---------------------------------------------------------------------------
  byte_item_t  pending_bytes[$];
  logic        expected_flags[$];
  logic [7:0]  frame_bytes[$];

  phase_t      phase          = PH_FREE;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          pushed_count   = 0;
  int          accepted_count = 0;
  int          error_count    = 0;
  int          quiet_cycles   = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;

  // ---------------------------------------------------------------------------
  // Scan predictor: mirrors both scanners byte by byte.
  // ---------------------------------------------------------------------------
  logic [23:0] scan_pos;
  logic [39:0] byte_hist;      // last five bytes, newest in [7:0]
  logic [23:0] annexb_resume;  // first position the start-code scan may test
  logic [31:0] unit_offset;    // offset of the next length prefix
  logic [31:0] unit_len;
  logic        walk_halted;
  logic        irap_found;

  function automatic void clear_scan();
    scan_pos      = '0;
    byte_hist     = '0;
    annexb_resume = '0;
    unit_offset   = '0;
    unit_len      = '0;
    walk_halted   = 1'b0;
    irap_found    = 1'b0;
  endfunction

  function automatic logic nal_is_irap(input logic [7:0] hdr);
    logic [5:0] nal_type;
    nal_type = hdr[6:1];
    return (nal_type >= IrapLow) && (nal_type <= IrapHigh);
  endfunction

  function automatic void predict_flag(input byte_item_t item);
    logic [63:0] p;
    logic [63:0] sz;
    logic [63:0] cand;
    logic [63:0] len;
    logic [7:0]  b0, b1, b2, b3;
    p         = 64'(scan_pos);
    sz        = 64'(item.buffer_length);
    byte_hist = {byte_hist[31:0], item.byte_value};
    if (sz >= 64'(MinLen) && p >= 64'd4) begin
      // Start-code scan: window holds data[p-4 .. p].
      cand = p - 64'd4;
      if (cand >= 64'(annexb_resume) && p + 64'd1 < sz) begin
        b0 = byte_hist[39:32];
        b1 = byte_hist[31:24];
        b2 = byte_hist[23:16];
        b3 = byte_hist[15:8];
        if (b0 == ZeroByte && b1 == ZeroByte) begin
          if (b2 == OneByte) begin
            if (nal_is_irap(b3)) irap_found = 1'b1;
            annexb_resume = 24'(cand + 64'd4);
          end else if (b2 == ZeroByte && b3 == OneByte) begin
            if (nal_is_irap(byte_hist[7:0])) irap_found = 1'b1;
            annexb_resume = 24'(cand + 64'd5);
          end
        end
      end
      // Length-prefix walk: prefix in data[p-4 .. p-1], unit header at p.
      if (!walk_halted && p == 64'(unit_offset) + 64'd4 && p < sz) begin
        len      = 64'(byte_hist[39:8]);
        unit_len = byte_hist[39:8];
        if (len == 64'd0 || p + len > sz) begin
          walk_halted = 1'b1;
        end else begin
          if (nal_is_irap(item.byte_value)) irap_found = 1'b1;
          unit_offset = 32'(p + len);
        end
      end
    end
    if (scan_pos != '1) scan_pos = scan_pos + 24'd1;
    if (item.last_byte) begin
      expected_flags.push_back(irap_found && (sz >= 64'(MinLen)));
      clear_scan();
    end
  endfunction

  function automatic void note_error(input string msg);
    if (error_count < MaxReports) $display("%s", msg);
    error_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: takes the next pending transaction when the channel is free, unless a random idle is drawn.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    byte_item_t item;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_bytes.pop_front();
        byte_ch.valid         <= 1'b1;
        byte_ch.byte_value    <= item.byte_value;
        byte_ch.buffer_length <= item.buffer_length;
        byte_ch.last_byte     <= item.last_byte;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off when the backpressure
  // phase starts so the result register fills and the input stalls on a last byte.
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      flag_ch.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (phase == PH_PRESSURE && !hold_done) begin
      flag_ch.ready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
    end else if (hold_left != 0) begin
      flag_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      flag_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every byte transaction, checks every flag transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    logic want;
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) begin
        predict_flag('{byte_value: byte_ch.byte_value,
                       buffer_length: byte_ch.buffer_length,
                       last_byte: byte_ch.last_byte});
        accepted_count++;
      end
      if (flag_ch.valid && flag_ch.ready) begin
        if (expected_flags.size() == 0) begin
          note_error($sformatf("unexpected result: keyframe_found=%0b",
                               flag_ch.keyframe_found));
        end else begin
          want = expected_flags.pop_front();
          if (flag_ch.keyframe_found !== want)
            note_error($sformatf("keyframe_found mismatch: expected %0b, got %0b",
                                 want, flag_ch.keyframe_found));
        end
      end
    end
  end

  // Watchdog: any transaction on either side resets the count.
  always @(posedge clk) begin : watchdog
    if (rst || (byte_ch.valid && byte_ch.ready) || (flag_ch.valid && flag_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transaction for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Buffer builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] random_byte();
    case ($urandom_range(3))
      0:       return ZeroByte;
      1:       return OneByte;
      default: return 8'($urandom);
    endcase
  endfunction

  // Types near and inside the IRAP range half the time.
  function automatic logic [7:0] random_header();
    logic [5:0] nal_type;
    if ($urandom_range(1)) nal_type = 6'($urandom_range(22, 15));
    else                   nal_type = 6'($urandom_range(63));
    return {1'($urandom_range(1)), nal_type, 1'($urandom_range(1))};
  endfunction

  function automatic void add_annexb_unit();
    if ($urandom_range(1)) frame_bytes.push_back(ZeroByte);
    frame_bytes.push_back(ZeroByte);
    frame_bytes.push_back(ZeroByte);
    frame_bytes.push_back(OneByte);
    frame_bytes.push_back(random_header());
    repeat ($urandom_range(5)) frame_bytes.push_back(random_byte());
  endfunction

  // Well-formed length prefix most of the time; zero, overrun or junk otherwise.
  function automatic void add_prefixed_unit();
    int unsigned body;
    logic [31:0] field;
    body  = $urandom_range(6, 1);
    field = body;
    case ($urandom_range(15))
      0:       field = '0;
      1:       field = body + $urandom_range(40, 1);
      2:       field = $urandom;
      default: ;
    endcase
    frame_bytes.push_back(field[31:24]);
    frame_bytes.push_back(field[23:16]);
    frame_bytes.push_back(field[15:8]);
    frame_bytes.push_back(field[7:0]);
    frame_bytes.push_back(random_header());
    repeat (body - 1) frame_bytes.push_back(random_byte());
  endfunction

  function automatic void build_random_frame();
    case ($urandom_range(9))
      0, 1, 2, 3: repeat ($urandom_range(3, 1)) add_annexb_unit();
      4, 5, 6:    repeat ($urandom_range(3, 1)) add_prefixed_unit();
      7:          repeat ($urandom_range(20, 1)) frame_bytes.push_back(random_byte());
      8: begin
        add_prefixed_unit();
        add_annexb_unit();
      end
      default:    repeat ($urandom_range(5, 1)) frame_bytes.push_back(random_byte());
    endcase
    if ($urandom_range(1)) repeat ($urandom_range(2, 1)) frame_bytes.push_back(random_byte());
  endfunction

  // Queues the frame as byte transactions. With pick_len the stated length is
  // usually exact, sometimes too long, too short, random, tiny or changing per byte.
  function automatic void send_frame(input bit pick_len, input logic [23:0] fixed_len);
    int          n;
    bit          wobble;
    logic [23:0] len;
    logic [23:0] this_len;
    n      = frame_bytes.size();
    len    = fixed_len;
    wobble = 1'b0;
    if (pick_len) begin
      len = 24'(n);
      case ($urandom_range(15))
        10:      len = 24'(n + $urandom_range(20, 1));
        11:      if (n > 4) len = 24'(n - $urandom_range(4, 1));
        12:      len = 24'($urandom);
        13:      len = 24'($urandom_range(5));
        14:      wobble = 1'b1;
        default: ;
      endcase
    end
    for (int k = 0; k < n; k++) begin
      this_len = (wobble && $urandom_range(1)) ? len ^ 24'($urandom_range(7, 1)) : len;
      pending_bytes.push_back('{byte_value: frame_bytes[k], buffer_length: this_len,
                                last_byte: (k == n - 1)});
      pushed_count++;
    end
    frame_bytes.delete();
  endfunction

  // Runs one traffic phase, then waits until every flag of it has come back.
  task automatic run_phase(input phase_t ph, input int send_pct, input int stall_pct,
                           input int budget);
    int first;
    @(negedge clk);
    phase          = ph;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    first          = pushed_count;
    while (pushed_count - first < budget) begin
      if (ph == PH_PRESSURE) begin
        add_annexb_unit();
        send_frame(1'b0, 24'(frame_bytes.size()));
      end else begin
        build_random_frame();
        send_frame(1'b1, '0);
      end
    end
    while (accepted_count != pushed_count || expected_flags.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_scan();
    rst                   = 1'b1;
    byte_ch.valid         = 1'b0;
    byte_ch.byte_value    = '0;
    byte_ch.buffer_length = '0;
    byte_ch.last_byte     = 1'b0;
    flag_ch.ready         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: buffer below the minimum length reports nothing even with a start code.
    frame_bytes = '{ZeroByte, ZeroByte, OneByte, 8'h26, ZeroByte};
    send_frame(1'b0, 24'd5);
    // Three-byte start code with an IRAP header at the minimum length.
    frame_bytes = '{ZeroByte, ZeroByte, OneByte, 8'h26, OneByte, 8'hFF};
    send_frame(1'b0, 24'd6);
    // Length-prefixed unit of two bytes, IRAP header (type 21).
    frame_bytes = '{ZeroByte, ZeroByte, ZeroByte, 8'h02, 8'h2A, 8'h80};
    send_frame(1'b0, 24'd6);
    // Four-byte start code, non-IRAP header, stated length far beyond the bytes sent.
    frame_bytes = '{ZeroByte, ZeroByte, ZeroByte, OneByte, 8'hFE, 8'h7F, ZeroByte};
    send_frame(1'b0, 24'hFFFFFF);

    run_phase(PH_FREE,       0,  0,  280);
    run_phase(PH_SEND_IDLE,  47, 0,  300);
    run_phase(PH_RECV_STALL, 0,  47, 300);
    run_phase(PH_BOTH,       18, 18, 300);
    run_phase(PH_PRESSURE,   0,  0,  100);
    run_phase(PH_FREE,       0,  0,  250);

    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_flags.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
src/kfd_pkg.sv
src/kfd_byte_if.sv
src/kfd_flag_if.sv
src/kfd_scan.sv
src/hevc_keyframe_detector_top.sv
tb/sv/hevc_keyframe_detector_top_tb.sv
